FILE: hdl/zph_pkg.sv
// Shared types, constants and the key generator step for the position hash.
package zph_pkg;

   // Key store layout
   localparam int unsigned STORE_DEPTH = 793;
   localparam int unsigned PIECE_KEYS  = 768;
   localparam int unsigned CASTLE_BASE = 768;
   localparam int unsigned CASTLE_KEYS = 16;
   localparam int unsigned EP_BASE     = 784;
   localparam int unsigned EP_KEYS     = 8;
   localparam int unsigned SIDE_INDEX  = 792;

   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned KEY_W       = 64;
   localparam int unsigned DRAW_W      = 16;
   localparam int unsigned DRAWS_PER_KEY = KEY_W / DRAW_W;

   // Generator
   localparam logic [31:0] SEED_WORD   = 32'd1804289371;
   localparam int unsigned XS_SHIFT_A  = 13;
   localparam int unsigned XS_SHIFT_B  = 17;
   localparam int unsigned XS_SHIFT_C  = 5;

   // Piece codes
   localparam logic [2:0] KIND_EMPTY   = 3'd0;
   localparam logic [2:0] KIND_LAST    = 3'd6;
   localparam int unsigned COLOR_OFFSET = 6;
   localparam int unsigned KEYS_PER_SQUARE = 12;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified square, as handed from front to back
   typedef struct packed {
      logic               piece_hit;
      logic [INDEX_W-1:0] piece_index;
      logic               last;
      logic               ep_valid;
      logic [2:0]         ep_file;
      logic [3:0]         castle_index;
      logic               black_to_move;
   } op_type;

   // One key written into the store during the fill
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] index;
      logic [KEY_W-1:0]   key;
   } fill_wr_type;

   // One xorshift32 step
   function automatic logic [31:0] zph_xorshift(input logic [31:0] w);
      logic [31:0] a;
      logic [31:0] b;
      a = w ^ (w << XS_SHIFT_A);
      b = a ^ (a >> XS_SHIFT_B);
      return b ^ (b << XS_SHIFT_C);
   endfunction

endpackage

FILE: hdl/zph_if.sv
// Square request and key response channel interfaces.
interface zph_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] square_file;
   logic [2:0] square_rank;
   logic [2:0] piece_kind;
   logic       piece_black;
   logic       last_square;
   logic       en_passant_valid;
   logic [2:0] en_passant_file;
   logic [1:0] white_castling;
   logic [1:0] black_castling;
   logic       black_to_move;

   modport source (
      output valid, square_file, square_rank, piece_kind, piece_black, last_square,
             en_passant_valid, en_passant_file, white_castling, black_castling,
             black_to_move,
      input  ready
   );
   modport sink (
      input  valid, square_file, square_rank, piece_kind, piece_black, last_square,
             en_passant_valid, en_passant_file, white_castling, black_castling,
             black_to_move,
      output ready
   );
endinterface

interface zph_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] position_key;

   modport source (output valid, position_key, input ready);
   modport sink   (input valid, position_key, output ready);
endinterface

FILE: hdl/zph_keygen.sv
// Key store fill sequencer: xorshift32 draws packed four to a key.
module zph_keygen
   import zph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   output fill_wr_type fill_wr,
   output logic        fill_done
);

   logic [31:0]               gen_ff;
   logic [31:0]               gen_in;
   logic [1:0]                draw_ff;
   logic [INDEX_W-1:0]        idx_ff;
   logic                      done_ff;
   logic [KEY_W-DRAW_W-1:0]   part_ff;

   // next draw
   always_comb begin
      gen_in = zph_xorshift(gen_ff);
   end

   // write beat when the fourth draw of a key comes out
   always_comb begin
      fill_wr.valid = !done_ff && (draw_ff == 2'(DRAWS_PER_KEY - 1));
      fill_wr.index = idx_ff;
      fill_wr.key   = {gen_in[DRAW_W-1:0], part_ff};
   end

   assign fill_done = done_ff;

   // draw sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= SEED_WORD;
         draw_ff <= '0;
         idx_ff  <= '0;
         done_ff <= 1'b0;
      end else if (!done_ff) begin
         gen_ff  <= gen_in;
         draw_ff <= draw_ff + 2'd1;
         if (draw_ff == 2'(DRAWS_PER_KEY - 1)) begin
            idx_ff <= idx_ff + INDEX_W'(1);
            if (idx_ff == INDEX_W'(STORE_DEPTH - 1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // low draws shift in from the top, lowest draw ends at the bottom
   always_ff @(posedge clock) begin
      if (!done_ff) begin
         part_ff <= {gen_in[DRAW_W-1:0], part_ff[KEY_W-DRAW_W-1:DRAW_W]};
      end
   end

endmodule

FILE: hdl/zph_front.sv
// Front stage: accepts squares and classifies them into key store operations.
module zph_front
   import zph_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   fill_done,
   zph_req_if.sink req_bus,
   output logic   push_valid,
   input  logic   push_ready,
   output op_type push_op
);

   logic   fs_valid_ff;
   op_type fs_op_ff;
   op_type op_in;
   logic   accept;
   logic [5:0]         square;
   logic [INDEX_W-1:0] square_base;
   logic [INDEX_W-1:0] piece_offset;

   assign req_bus.ready = fill_done && (!fs_valid_ff || push_ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign push_valid    = fs_valid_ff;
   assign push_op       = fs_op_ff;

   // classify: piece key index is square*12 + (kind-1) + 6*black
   always_comb begin
      square       = {req_bus.square_file, req_bus.square_rank};
      square_base  = (INDEX_W'(square) << 3) + (INDEX_W'(square) << 2);
      piece_offset = INDEX_W'(req_bus.piece_kind - 3'd1)
                     + (req_bus.piece_black ? INDEX_W'(COLOR_OFFSET) : '0);
      op_in.piece_hit     = (req_bus.piece_kind != KIND_EMPTY)
                            && (req_bus.piece_kind <= KIND_LAST);
      op_in.piece_index   = op_in.piece_hit ? square_base + piece_offset : '0;
      op_in.last          = req_bus.last_square;
      op_in.ep_valid      = req_bus.en_passant_valid;
      op_in.ep_file       = req_bus.en_passant_file;
      op_in.castle_index  = {req_bus.white_castling, req_bus.black_castling};
      op_in.black_to_move = req_bus.black_to_move;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_valid_ff <= 1'b0;
      end else if (accept) begin
         fs_valid_ff <= 1'b1;
      end else if (push_ready) begin
         fs_valid_ff <= 1'b0;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         fs_op_ff <= op_in;
      end
   end

endmodule

FILE: hdl/zph_queue.sv
// Short FIFO of classified operations between front and back.
module zph_queue
   import zph_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   op_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: hdl/zph_back.sv
// Back end: key store, key read, running XOR and the result register.
module zph_back
   import zph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fill_wr_type fill_wr,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  op_type      pop_op,
   zph_rsp_if.source   rsp_bus
);

   logic [KEY_W-1:0] piece_mem  [PIECE_KEYS];
   logic [KEY_W-1:0] castle_ff  [CASTLE_KEYS];
   logic [KEY_W-1:0] ep_ff      [EP_KEYS];
   logic [KEY_W-1:0] side_ff;

   logic             s1_valid_ff;
   op_type           s1_op_ff;
   logic [KEY_W-1:0] rd_ff;
   logic [KEY_W-1:0] acc_ff;
   logic [KEY_W-1:0] acc_in;
   logic             out_valid_ff;
   logic [KEY_W-1:0] out_key_ff;
   logic [KEY_W-1:0] out_key_in;

   logic             s1_go;
   logic             do_pop;
   logic [3:0]       castle_wr_idx;
   logic [2:0]       ep_wr_idx;

   // stage 1 moves on unless a finished key has nowhere to go
   assign s1_go     = s1_valid_ff
                      && (!s1_op_ff.last || !out_valid_ff || rsp_bus.ready);
   assign pop_ready = !s1_valid_ff || s1_go;
   assign do_pop    = pop_valid && pop_ready;

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.position_key = out_key_ff;

   assign castle_wr_idx = 4'(fill_wr.index - INDEX_W'(CASTLE_BASE));
   assign ep_wr_idx     = 3'(fill_wr.index - INDEX_W'(EP_BASE));

   // fill writes into the piece memory
   always_ff @(posedge clock) begin
      if (fill_wr.valid && (fill_wr.index < INDEX_W'(PIECE_KEYS))) begin
         piece_mem[fill_wr.index] <= fill_wr.key;
      end
   end

   // fill writes into the small key tables
   always_ff @(posedge clock) begin
      if (fill_wr.valid) begin
         if ((fill_wr.index >= INDEX_W'(CASTLE_BASE)) && (fill_wr.index < INDEX_W'(EP_BASE))) begin
            castle_ff[castle_wr_idx] <= fill_wr.key;
         end
         if ((fill_wr.index >= INDEX_W'(EP_BASE)) && (fill_wr.index < INDEX_W'(SIDE_INDEX))) begin
            ep_ff[ep_wr_idx] <= fill_wr.key;
         end
         if (fill_wr.index == INDEX_W'(SIDE_INDEX)) begin
            side_ff <= fill_wr.key;
         end
      end
   end

   // registered piece key read, held while stage 1 stalls
   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_ff    <= piece_mem[pop_op.piece_index];
         s1_op_ff <= pop_op;
      end
   end

   // fold the square into the running key, finish on the last square
   always_comb begin
      logic [KEY_W-1:0] piece_key;
      piece_key  = s1_op_ff.piece_hit ? rd_ff : '0;
      acc_in     = s1_op_ff.last ? '0 : (acc_ff ^ piece_key);
      out_key_in = acc_ff ^ piece_key
                   ^ (s1_op_ff.ep_valid ? ep_ff[s1_op_ff.ep_file] : '0)
                   ^ castle_ff[s1_op_ff.castle_index]
                   ^ (s1_op_ff.black_to_move ? side_ff : '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (do_pop) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            acc_ff <= acc_in;
         end
         if (s1_go && s1_op_ff.last) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (s1_go && s1_op_ff.last) begin
         out_key_ff <= out_key_in;
      end
   end

endmodule

FILE: hdl/zobrist_position_hash_top.sv
// Zobrist position hash: one board square per beat in, one 64-bit key per position out.
//
// After reset the block fills its 793-key store from an xorshift32 generator,
// one generator step per clock and four steps per key, and req_bus.ready stays low
// until the fill is done. From then on it takes one square per clock while the
// queue has room: the front stage classifies the square into a piece key index, a
// four-entry queue decouples it from the back end, and the back end does one read
// of the single-port piece key memory and one XOR per square. Castling, en passant
// and side keys sit in flip-flop tables and are folded in on the last square. The
// key passes the front stage register, the queue and the stage 1 read register into
// the result register; a stalled result stalls the back end only when the next key
// is ready to leave, and the queue absorbs the front meanwhile.
module zobrist_position_hash_top
   import zph_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   zph_req_if.sink   req_bus,
   zph_rsp_if.source rsp_bus
);

   fill_wr_type fill_wr;
   logic        fill_done;
   logic        push_valid;
   logic        push_ready;
   op_type      push_op;
   logic        pop_valid;
   logic        pop_ready;
   op_type      pop_op;

   zph_keygen u_keygen (
      .clock     (clock),
      .reset     (reset),
      .fill_wr   (fill_wr),
      .fill_done (fill_done)
   );

   zph_front u_front (
      .clock      (clock),
      .reset      (reset),
      .fill_done  (fill_done),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   zph_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   zph_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fill_wr   (fill_wr),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op),
      .rsp_bus   (rsp_bus)
   );

   // no squares taken while the key store fills
   a_no_accept_in_fill: assert property (@(posedge clock) disable iff (reset)
      !fill_done |-> !req_bus.ready)
      else $error("square accepted during key fill");

   // the fill completes once and stays complete
   a_fill_sticky: assert property (@(posedge clock) disable iff (reset)
      fill_done |=> fill_done)
      else $error("fill done dropped");

   // no key store writes after the fill
   a_no_write_after_fill: assert property (@(posedge clock) disable iff (reset)
      fill_done |-> !fill_wr.valid)
      else $error("key store written after fill");

   // nothing reaches the back end or the output before the store is complete
   a_quiet_in_fill: assert property (@(posedge clock) disable iff (reset)
      !fill_done |-> !pop_valid && !rsp_bus.valid)
      else $error("activity during key fill");

endmodule
